// ----- src/progress_target_watchdog_unit_defines.svh -----
// assertion macros for the progress target watchdog
`ifndef PROGRESS_TARGET_WATCHDOG_UNIT_DEFINES_SVH
`define PROGRESS_TARGET_WATCHDOG_UNIT_DEFINES_SVH
`ifndef SYNTH
`define PTW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTW_ASSERT_IMPLIES(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define PTW_ASSERT(lbl, prop, msg)
`define PTW_ASSERT_IMPLIES(lbl, pre, post, msg)
`endif
`endif

// ----- src/ptw_pkg.sv -----
// shared types, codes and constant functions for the progress target watchdog
package ptw_pkg;

    localparam int DATE_W      = 32;
    localparam int TIME_W      = 64;
    localparam int RUN_DAYS_W  = 20;
    localparam int TIMEOUT_W   = 17;
    localparam int LIMIT_W     = 37;
    localparam int DAYS_MAX    = 1000000;
    localparam int TIMEOUT_MAX = 86400;
    localparam int US_PER_SEC  = 1000000;

    localparam logic CMD_ARM     = 1'b0;
    localparam logic CMD_OBSERVE = 1'b1;

    localparam logic [1:0] PAUSE_RUNNING = 2'd0;
    localparam logic [1:0] PAUSE_PAUSED  = 2'd1;

    typedef enum logic [2:0] {
        ACT_CONTINUE = 3'd0,
        ACT_COMPLETE = 3'd1,
        ACT_FAIL     = 3'd2,
        ACT_ARMED    = 3'd3,
        ACT_REJECT   = 3'd4
    } action_t;

    typedef enum logic [3:0] {
        CAUSE_NONE             = 4'd0,
        CAUSE_BAD_COND         = 4'd1,
        CAUSE_DAYS_RANGE       = 4'd2,
        CAUSE_BAD_TARGET       = 4'd3,
        CAUSE_UNAVAILABLE      = 4'd4,
        CAUSE_BAD_PAUSE        = 4'd5,
        CAUSE_ENDED            = 4'd6,
        CAUSE_INVARIANT        = 4'd7,
        CAUSE_REGRESSED        = 4'd8,
        CAUSE_OVERSHOOT        = 4'd9,
        CAUSE_TIMEOUT          = 4'd10,
        CAUSE_UNEXPECTED_PAUSE = 4'd11
    } cause_t;

    typedef enum logic [2:0] {
        CFG_START_DATE    = 3'd0,
        CFG_HAS_DAYS      = 3'd1,
        CFG_RUN_DAYS      = 3'd2,
        CFG_HAS_TARGET    = 3'd3,
        CFG_TARGET_GOAL   = 3'd4,
        CFG_TIMEOUT_SECS  = 3'd5,
        CFG_START_TIME_US = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic                     ok;
        cause_t                   cause;
        logic signed [DATE_W-1:0] goal;
        logic [LIMIT_W-1:0]       limit_us;
    } arm_check_t;

    function automatic int trailing_zeros(int v);
        int   n;
        logic done;
        n    = 0;
        done = 1'b0;
        for (int i = 0; i < 16; i++)
        begin
            if (!done)
            begin
                if (((v >>> i) & 1) != 0)
                    done = 1'b1;
                else
                    n = n + 1;
            end
        end
        return n;
    endfunction

    // inverse of an odd number modulo 2^32 by newton steps
    function automatic logic [31:0] odd_inverse(logic [31:0] o);
        logic [31:0] x;
        x = o;
        for (int i = 0; i < 5; i++)
        begin
            x = x * (32'd2 - o * x);
        end
        return x;
    endfunction

endpackage

// ----- src/progress_target_watchdog_unit.sv -----
// progress target watchdog: run monitor with arm and observe commands
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------------
//  input    | in        | in_valid / in_stall  | cmd, tool_available, date_present,
//           |           |                      | obs_date, pause_code, ended,
//           |           |                      | checks_ok, now_us
//  output   | out       | out_valid / out_stall| action, cause
//  config   | in        | wr_en                | wr_index, wr_data
//
//  one word per cycle while in_stall is low; a word is held in the input register,
//  then its result is held in the result register, where it is ready to be taken
//  the run state updates as a word moves from input to result register
//  reset clears configuration, run state and both valid flags
//  out_stall holds the result register and backs up into in_stall only when
//  the input register is also full
`include "progress_target_watchdog_unit_defines.svh"

module progress_target_watchdog_unit #(
    parameter int UNITS_PER_DAY = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                cmd,
    input  logic                                tool_available,
    input  logic                                date_present,
    input  logic signed [ptw_pkg::DATE_W-1:0]   obs_date,
    input  logic [1:0]                          pause_code,
    input  logic                                ended,
    input  logic                                checks_ok,
    input  logic [ptw_pkg::TIME_W-1:0]          now_us,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          action,
    output logic [3:0]                          cause,
    input  logic                                wr_en,
    input  logic [2:0]                          wr_index,
    input  logic [ptw_pkg::TIME_W-1:0]          wr_data
);

    localparam int DW = ptw_pkg::DATE_W;
    localparam int TW = ptw_pkg::TIME_W;

    // configuration
    logic signed [DW-1:0]               start_date_reg;
    logic                               has_days_reg;
    logic [ptw_pkg::RUN_DAYS_W-1:0]     run_days_reg;
    logic                               has_target_reg;
    logic signed [DW-1:0]               target_goal_reg;
    logic [ptw_pkg::TIMEOUT_W-1:0]      timeout_secs_reg;
    logic [TW-1:0]                      start_time_us_reg;

    // input register
    logic                               in_valid_reg;
    logic                               cmd_reg;
    logic                               tool_available_reg;
    logic                               date_present_reg;
    logic signed [DW-1:0]               obs_date_reg;
    logic [1:0]                         pause_code_reg;
    logic                               ended_reg;
    logic                               checks_ok_reg;
    logic [TW-1:0]                      now_us_reg;

    // run state
    logic                               running_reg;
    logic                               running_next;
    logic signed [DW-1:0]               goal_date_reg;
    logic signed [DW-1:0]               goal_date_next;
    logic signed [DW-1:0]               last_date_reg;
    logic signed [DW-1:0]               last_date_next;
    logic                               pause_at_goal_reg;
    logic                               pause_at_goal_next;
    logic [ptw_pkg::LIMIT_W-1:0]        limit_us_reg;
    logic [ptw_pkg::LIMIT_W-1:0]        limit_us_next;
    logic [TW-1:0]                      start_us_reg;
    logic [TW-1:0]                      start_us_next;

    // result register
    logic                               out_valid_reg;
    ptw_pkg::action_t                   action_reg;
    ptw_pkg::action_t                   action_next;
    ptw_pkg::cause_t                    cause_reg;
    ptw_pkg::cause_t                    cause_next;

    logic                               advance;
    logic                               fire;
    logic                               paused;
    logic [TW:0]                        elapsed;
    logic                               past_limit;
    ptw_pkg::arm_check_t                arm_res;

    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign action    = action_reg;
    assign cause     = cause_reg;

    ptw_arm_check #(
        .UNITS_PER_DAY (UNITS_PER_DAY)
    ) u_arm_check (
        .start_date   (start_date_reg),
        .has_days     (has_days_reg),
        .run_days     (run_days_reg),
        .has_target   (has_target_reg),
        .target_goal  (target_goal_reg),
        .timeout_secs (timeout_secs_reg),
        .result       (arm_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_date_reg    <= '0;
            has_days_reg      <= 1'b0;
            run_days_reg      <= '0;
            has_target_reg    <= 1'b0;
            target_goal_reg   <= '0;
            timeout_secs_reg  <= '0;
            start_time_us_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                ptw_pkg::CFG_START_DATE:    start_date_reg    <= wr_data[DW-1:0];
                ptw_pkg::CFG_HAS_DAYS:      has_days_reg      <= wr_data[0];
                ptw_pkg::CFG_RUN_DAYS:      run_days_reg      <= wr_data[ptw_pkg::RUN_DAYS_W-1:0];
                ptw_pkg::CFG_HAS_TARGET:    has_target_reg    <= wr_data[0];
                ptw_pkg::CFG_TARGET_GOAL:   target_goal_reg   <= wr_data[DW-1:0];
                ptw_pkg::CFG_TIMEOUT_SECS:  timeout_secs_reg  <= wr_data[ptw_pkg::TIMEOUT_W-1:0];
                ptw_pkg::CFG_START_TIME_US: start_time_us_reg <= wr_data;
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg            <= cmd;
            tool_available_reg <= tool_available;
            date_present_reg   <= date_present;
            obs_date_reg       <= obs_date;
            pause_code_reg     <= pause_code;
            ended_reg          <= ended;
            checks_ok_reg      <= checks_ok;
            now_us_reg         <= now_us;
        end
    end

    assign paused     = (pause_code_reg == ptw_pkg::PAUSE_PAUSED);
    assign elapsed    = {1'b0, now_us_reg} - {1'b0, start_us_reg};
    assign past_limit = elapsed[TW] || (elapsed[TW-1:0] >= TW'(limit_us_reg));

    always_comb
    begin
        running_next       = running_reg;
        goal_date_next     = goal_date_reg;
        last_date_next     = last_date_reg;
        pause_at_goal_next = pause_at_goal_reg;
        limit_us_next      = limit_us_reg;
        start_us_next      = start_us_reg;
        action_next        = ptw_pkg::ACT_CONTINUE;
        cause_next         = ptw_pkg::CAUSE_NONE;
        if (cmd_reg == ptw_pkg::CMD_ARM)
        begin
            running_next = 1'b0;
            if (arm_res.ok)
            begin
                running_next       = 1'b1;
                goal_date_next     = arm_res.goal;
                last_date_next     = start_date_reg;
                pause_at_goal_next = 1'b0;
                limit_us_next      = arm_res.limit_us;
                start_us_next      = start_time_us_reg;
                action_next        = ptw_pkg::ACT_ARMED;
            end
            else
            begin
                action_next = ptw_pkg::ACT_REJECT;
                cause_next  = arm_res.cause;
            end
        end
        else if (running_reg)
        begin
            action_next  = ptw_pkg::ACT_FAIL;
            running_next = 1'b0;
            priority if (!tool_available_reg || !date_present_reg)
                cause_next = ptw_pkg::CAUSE_UNAVAILABLE;
            else if (pause_code_reg > ptw_pkg::PAUSE_PAUSED)
                cause_next = ptw_pkg::CAUSE_BAD_PAUSE;
            else if (ended_reg)
                cause_next = ptw_pkg::CAUSE_ENDED;
            else if (!checks_ok_reg)
                cause_next = ptw_pkg::CAUSE_INVARIANT;
            else if (obs_date_reg < last_date_reg)
                cause_next = ptw_pkg::CAUSE_REGRESSED;
            else
            begin
                last_date_next = obs_date_reg;
                priority if (obs_date_reg > goal_date_reg)
                    cause_next = ptw_pkg::CAUSE_OVERSHOOT;
                else if (obs_date_reg == goal_date_reg)
                begin
                    priority if (paused && pause_at_goal_reg)
                        action_next = ptw_pkg::ACT_COMPLETE;
                    else if (past_limit)
                        cause_next = ptw_pkg::CAUSE_TIMEOUT;
                    else
                    begin
                        action_next        = ptw_pkg::ACT_CONTINUE;
                        running_next       = 1'b1;
                        pause_at_goal_next = paused;
                    end
                end
                else if (paused)
                    cause_next = ptw_pkg::CAUSE_UNEXPECTED_PAUSE;
                else if (past_limit)
                    cause_next = ptw_pkg::CAUSE_TIMEOUT;
                else
                begin
                    action_next  = ptw_pkg::ACT_CONTINUE;
                    running_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg       <= 1'b0;
            goal_date_reg     <= '0;
            last_date_reg     <= '0;
            pause_at_goal_reg <= 1'b0;
            limit_us_reg      <= '0;
            start_us_reg      <= '0;
        end
        else if (fire)
        begin
            running_reg       <= running_next;
            goal_date_reg     <= goal_date_next;
            last_date_reg     <= last_date_next;
            pause_at_goal_reg <= pause_at_goal_next;
            limit_us_reg      <= limit_us_next;
            start_us_reg      <= start_us_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            action_reg <= action_next;
            cause_reg  <= cause_next;
        end
    end

    `PTW_ASSERT_IMPLIES(a_start_is_armed, $rose(running_reg),
        out_valid_reg && action_reg == ptw_pkg::ACT_ARMED,
        "run started without an armed word")
    `PTW_ASSERT_IMPLIES(a_stop_has_end, $fell(running_reg),
        out_valid_reg && (action_reg == ptw_pkg::ACT_COMPLETE
            || action_reg == ptw_pkg::ACT_FAIL || action_reg == ptw_pkg::ACT_REJECT),
        "run stopped without an ending word")
    `PTW_ASSERT_IMPLIES(a_cause_only_on_error,
        out_valid_reg && action_reg != ptw_pkg::ACT_FAIL && action_reg != ptw_pkg::ACT_REJECT,
        cause_reg == ptw_pkg::CAUSE_NONE, "cause set on a non error word")
    `PTW_ASSERT_IMPLIES(a_no_stall_when_empty, !out_valid_reg, !in_stall,
        "input stalled with an empty result register")
    `PTW_ASSERT_IMPLIES(a_state_holds_idle, !$past(fire),
        $stable(running_reg) && $stable(last_date_reg), "run state moved without a word")

endmodule

// ----- src/ptw_arm_check.sv -----
// goal and timeout validation for the arm command
module ptw_arm_check #(
    parameter int UNITS_PER_DAY = 24
) (
    input  logic signed [ptw_pkg::DATE_W-1:0]   start_date,
    input  logic                                has_days,
    input  logic [ptw_pkg::RUN_DAYS_W-1:0]      run_days,
    input  logic                                has_target,
    input  logic signed [ptw_pkg::DATE_W-1:0]   target_goal,
    input  logic [ptw_pkg::TIMEOUT_W-1:0]       timeout_secs,
    output ptw_pkg::arm_check_t                 result
);

    localparam int UPD_W   = $clog2(UNITS_PER_DAY + 1);
    localparam int PROD_W  = ptw_pkg::RUN_DAYS_W + UPD_W;
    localparam int SUM_W   = ((PROD_W > ptw_pkg::DATE_W) ? PROD_W : ptw_pkg::DATE_W) + 2;
    localparam int DW      = ptw_pkg::DATE_W;
    localparam int UPD_TZ  = ptw_pkg::trailing_zeros(UNITS_PER_DAY);
    localparam int UPD_ODD = UNITS_PER_DAY >> UPD_TZ;
    localparam logic [DW-1:0] ODD_INV   = ptw_pkg::odd_inverse(DW'(UPD_ODD));
    localparam logic [DW-1:0] ODD_LIMIT = DW'(64'h0000_0000_FFFF_FFFF / UPD_ODD);
    localparam logic [DW-1:0] TZ_MASK   = DW'((64'd1 << UPD_TZ) - 64'd1);

    logic                    cond_bad;
    logic                    days_bad;
    logic [PROD_W-1:0]       days_prod;
    logic signed [SUM_W-1:0] days_tgt;
    logic                    days_fit;
    logic signed [DW:0]      tdiff;
    logic                    tdiff_pos;
    logic [DW-1:0]           odd_part;
    logic [DW-1:0]           odd_prod;
    logic                    div_ok;

    assign cond_bad = (has_days == has_target)
                   || (timeout_secs < ptw_pkg::TIMEOUT_W'(1))
                   || (timeout_secs > ptw_pkg::TIMEOUT_W'(ptw_pkg::TIMEOUT_MAX));
    assign days_bad = (run_days < ptw_pkg::RUN_DAYS_W'(1))
                   || (run_days > ptw_pkg::RUN_DAYS_W'(ptw_pkg::DAYS_MAX));

    assign days_prod = PROD_W'(run_days) * PROD_W'(UNITS_PER_DAY);
    assign days_tgt  = SUM_W'(start_date) + $signed(SUM_W'(days_prod));
    assign days_fit  = (days_tgt[SUM_W-1:DW-1] == '0) || (days_tgt[SUM_W-1:DW-1] == '1);

    assign tdiff     = (DW+1)'(target_goal) - (DW+1)'(start_date);
    assign tdiff_pos = !tdiff[DW] && (tdiff[DW-1:0] != '0);
    assign odd_part  = tdiff[DW-1:0] >> UPD_TZ;
    assign odd_prod  = odd_part * ODD_INV;
    assign div_ok    = ((tdiff[DW-1:0] & TZ_MASK) == '0) && (odd_prod <= ODD_LIMIT);

    always_comb
    begin
        result.ok       = 1'b0;
        result.cause    = ptw_pkg::CAUSE_NONE;
        result.goal     = target_goal;
        result.limit_us = ptw_pkg::LIMIT_W'(timeout_secs)
                        * ptw_pkg::LIMIT_W'(ptw_pkg::US_PER_SEC);
        if (cond_bad)
        begin
            result.cause = ptw_pkg::CAUSE_BAD_COND;
        end
        else if (has_days)
        begin
            if (days_bad)
                result.cause = ptw_pkg::CAUSE_DAYS_RANGE;
            else if (!days_fit)
                result.cause = ptw_pkg::CAUSE_BAD_TARGET;
            else
            begin
                result.ok   = 1'b1;
                result.goal = days_tgt[DW-1:0];
            end
        end
        else
        begin
            if (!tdiff_pos || !div_ok)
                result.cause = ptw_pkg::CAUSE_BAD_TARGET;
            else
                result.ok = 1'b1;
        end
    end

endmodule
